@@ design/aots_pkg.sv @@
// Package for the alien order sorter: word types, controller states and
// the command/status structs between controller and datapath. No dependencies.
package aots_pkg;

	typedef struct packed {
		logic [4:0] symbol;
		logic       word_end;
		logic       list_end;
	} in_word_t;

	typedef struct packed {
		logic [4:0] letter;
		logic       last_of_order;
		logic       order_empty;
	} out_word_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_COUNT,
		ST_SORT
	} state_t;

	typedef struct packed {
		logic take;       // accept one input word
		logic cnt_step;   // add one matrix row into the predecessor counts
		logic sort_step;  // pick one ready letter
		logic clear;      // wipe all per-list state
	} cmd_t;

	typedef struct packed {
		logic row_last;   // counting is at the final row
		logic any_ready;  // some letter is ready to be emitted
	} stat_t;

	localparam int LETTERS = 32;

endpackage

@@ design/aots_ctrl.sv @@
// Controller state machine for the alien order sorter.
// Depends on aots_pkg for the state enum and the command/status structs.
module aots_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          list_fin,
	input  aots_pkg::stat_t st,
	output aots_pkg::cmd_t  cmd,
	output logic          busy
);
	import aots_pkg::*;

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd = '0;
		busy = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.take = 1'b1;
					if (list_fin) state_nxt = ST_COUNT;
				end
			end
			ST_COUNT: begin
				cmd.cnt_step = 1'b1;
				if (st.row_last) state_nxt = ST_SORT;
			end
			ST_SORT: begin
				cmd.sort_step = 1'b1;
				if (!st.any_ready) begin
					cmd.clear = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

@@ design/aots_dp.sv @@
// Datapath of the alien order sorter: word history memory, precedence
// matrix, predecessor counters and result register. Depends on aots_pkg.
module aots_dp #(
	parameter int ALPHABET     = 32,
	parameter int MAX_WORD_LEN = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  aots_pkg::cmd_t     cmd,
	input  aots_pkg::in_word_t item,
	output aots_pkg::stat_t    st,
	output aots_pkg::out_word_t result,
	output logic               strobe
);
	import aots_pkg::*;

	localparam int PW = $clog2(MAX_WORD_LEN + 1);
	localparam int AW = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;

	logic [4:0]       hist_mem [MAX_WORD_LEN];
	logic [4:0]       prev_q;
	logic [PW-1:0]    pos_q, plen_q, pos_inc, rd_pos;
	logic [AW-1:0]    rd_addr, wr_addr;
	logic             div_q, first_q;
	logic [LETTERS-1:0] mat_q [LETTERS];
	logic [LETTERS-1:0] present_q, emitted_q, ready, row;
	logic [5:0]       cnt_q [LETTERS];
	logic [4:0]       row_q, pick, row_addr, pick_q;
	logic             have_q, pos_ok, sym_ok, prev_ok, cmp_en, any;
	out_word_t        result_q;
	logic             strobe_q;

	assign pos_ok  = pos_q < PW'(MAX_WORD_LEN);
	assign sym_ok  = {2'b00, item.symbol} < 7'(ALPHABET);
	assign prev_ok = {2'b00, prev_q} < 7'(ALPHABET);
	assign pos_inc = pos_ok ? pos_q + 1'b1 : pos_q;
	assign wr_addr = pos_q[AW-1:0];
	assign cmp_en  = cmd.take && pos_ok && !first_q && !div_q && (pos_q < plen_q)
		&& (prev_q != item.symbol);

	// The history is read one position ahead so the stored letter is ready
	// when the next word arrives.
	always_comb begin
		rd_pos = pos_q;
		if (cmd.take) rd_pos = item.word_end ? '0 : pos_inc;
		rd_addr = (rd_pos < PW'(MAX_WORD_LEN)) ? rd_pos[AW-1:0] : '0;
	end

	always_ff @(posedge clk) begin
		if (cmd.take && pos_ok) hist_mem[wr_addr] <= item.symbol;
		if (cmd.take && pos_ok && wr_addr == rd_addr) prev_q <= item.symbol;
		else prev_q <= hist_mem[rd_addr];
	end

	always_comb begin
		ready = '0;
		pick = '0;
		for (int v = 0; v < LETTERS; v++) begin
			ready[v] = present_q[v] && !emitted_q[v] && (cnt_q[v] == '0);
			if (ready[v]) pick = 5'(v);
		end
		any = |ready;
		row_addr = cmd.cnt_step ? row_q : pick;
		row = mat_q[row_addr];
	end

	assign st.any_ready = any;
	assign st.row_last  = row_q == 5'(LETTERS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			plen_q <= '0;
			div_q <= 1'b0;
			first_q <= 1'b1;
			present_q <= '0;
			emitted_q <= '0;
			row_q <= '0;
			have_q <= 1'b0;
			pick_q <= '0;
			for (int i = 0; i < LETTERS; i++) begin
				mat_q[i] <= '0;
				cnt_q[i] <= '0;
			end
		end else if (cmd.clear) begin
			pos_q <= '0;
			plen_q <= '0;
			div_q <= 1'b0;
			first_q <= 1'b1;
			present_q <= '0;
			emitted_q <= '0;
			row_q <= '0;
			have_q <= 1'b0;
			for (int i = 0; i < LETTERS; i++) begin
				mat_q[i] <= '0;
				cnt_q[i] <= '0;
			end
		end else begin
			if (cmd.take) begin
				if (pos_ok && first_q && pos_q == '0 && sym_ok)
					present_q[item.symbol] <= 1'b1;
				if (cmp_en) begin
					div_q <= 1'b1;
					if (prev_ok && sym_ok) begin
						mat_q[prev_q][item.symbol] <= 1'b1;
						present_q[prev_q] <= 1'b1;
						present_q[item.symbol] <= 1'b1;
					end
				end
				pos_q <= pos_inc;
				if (item.word_end) begin
					plen_q <= pos_inc;
					pos_q <= '0;
					div_q <= 1'b0;
					first_q <= 1'b0;
				end
			end
			if (cmd.cnt_step) begin
				row_q <= row_q + 1'b1;
				if (present_q[row_q]) begin
					for (int v = 0; v < LETTERS; v++)
						if (row[v]) cnt_q[v] <= cnt_q[v] + 1'b1;
				end
			end
			if (cmd.sort_step && any) begin
				emitted_q[pick] <= 1'b1;
				pick_q <= pick;
				have_q <= 1'b1;
				for (int v = 0; v < LETTERS; v++)
					if (row[v] && cnt_q[v] != '0) cnt_q[v] <= cnt_q[v] - 1'b1;
			end
		end
	end

	// A pick is held in pick_q and shown through result_q, once it is known whether another follows.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.sort_step && (have_q || !any);
		end
	end

	always_ff @(posedge clk) begin
		result_q.letter        <= have_q ? pick_q : '0;
		result_q.last_of_order <= !any;
		result_q.order_empty   <= !any && !have_q;
	end

	assign result = result_q;
	assign strobe = strobe_q;

endmodule

@@ design/alien_order_topological_sort.sv @@
// Top level of the alien order sorter: controller plus datapath.
// Depends on aots_pkg, aots_ctrl and aots_dp.
//
//  channel | ports                 | handshake
//  input   | item (in_word_t)      | taken when start=1 and busy=0
//  result  | result (out_word_t)   | valid for one cycle while strobe=1
//
// Each input word is taken in one cycle, back to back, while busy is low.
// After the list end word, the controller walks every matrix row to build
// predecessor counts, then picks ready letters until none is left; busy stays
// high until the last result appears. Each pick passes via pick_q into result_q.
// Reset spares the history, prev_q and result_q; the result side cannot stall.
module alien_order_topological_sort #(
	parameter int ALPHABET     = 32,
	parameter int MAX_WORD_LEN = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  aots_pkg::in_word_t  item,
	output aots_pkg::out_word_t result,
	output logic                strobe
);
	import aots_pkg::*;

	cmd_t  cmd;
	stat_t st;

	aots_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.list_fin (item.word_end & item.list_end),
		.st       (st),
		.cmd      (cmd),
		.busy     (busy)
	);

	aots_dp #(
		.ALPHABET     (ALPHABET),
		.MAX_WORD_LEN (MAX_WORD_LEN)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (item),
		.st     (st),
		.result (result),
		.strobe (strobe)
	);

endmodule
